### hdl/mag_calibrate_tilt_heading_top_macros.svh
// assertion macros shared by the heading engine
`ifndef MAG_CALIBRATE_TILT_HEADING_TOP_MACROS_SVH
`define MAG_CALIBRATE_TILT_HEADING_TOP_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define MTH_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("heading engine check failed");

// next-cycle implication
`define MTH_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("heading engine check failed");

`endif

### hdl/mth_pkg.sv
// ----------------------------------------------------------------------------
// mth_pkg
// Types, codes and constants shared by the magnetometer heading engine.
// ----------------------------------------------------------------------------
package mth_pkg;

   localparam int CORDIC_W       = 52;
   localparam int ANGLE_W        = 26;
   localparam int FULL_TURN      = 92160;
   localparam int HALF_TURN      = 46080;
   localparam int QUARTER_TURN   = 23040;
   localparam int CORDIC_K_Q30   = 652032874;
   localparam int HALF_TURN_FINE = 11796480;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_SAMPLE  = 2'd1,
      OP_FINISH  = 2'd2,
      OP_HEADING = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_SPAN = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROT_P,
      ST_ROT_R,
      ST_MUL,
      ST_VEC_START,
      ST_VEC,
      ST_DIV_X_START,
      ST_DIV_X,
      ST_DIV_Y
   } state_type;

   typedef enum logic [3:0] {
      MS_CX,
      MS_CY,
      MS_XSR,
      MS_ZSR,
      MS_XCP,
      MS_ZSP,
      MS_YCR,
      MS_T1SP,
      MS_T2CP,
      MS_NONE
   } mul_sel_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_ctrl_type;

   // arctangent of 2^-i in 2^-16 degree
   function automatic logic signed [ANGLE_W-1:0] angle_entry(input logic [4:0] i);
      logic signed [ANGLE_W-1:0] a;
      case (i)
         5'd0:    a = 26'sd2949120;
         5'd1:    a = 26'sd1740967;
         5'd2:    a = 26'sd919879;
         5'd3:    a = 26'sd466945;
         5'd4:    a = 26'sd234379;
         5'd5:    a = 26'sd117304;
         5'd6:    a = 26'sd58666;
         5'd7:    a = 26'sd29335;
         5'd8:    a = 26'sd14668;
         5'd9:    a = 26'sd7334;
         5'd10:   a = 26'sd3667;
         5'd11:   a = 26'sd1833;
         5'd12:   a = 26'sd917;
         5'd13:   a = 26'sd458;
         5'd14:   a = 26'sd229;
         5'd15:   a = 26'sd115;
         5'd16:   a = 26'sd57;
         5'd17:   a = 26'sd29;
         5'd18:   a = 26'sd14;
         5'd19:   a = 26'sd7;
         5'd20:   a = 26'sd4;
         5'd21:   a = 26'sd2;
         5'd22:   a = 26'sd1;
         default: a = 26'sd0;
      endcase
      return a;
   endfunction

endpackage

### hdl/mag_calibrate_tilt_heading_top.sv
// ----------------------------------------------------------------------------
// mag_calibrate_tilt_heading_top
// Magnetometer calibration and tilt-compensated heading engine.
// ----------------------------------------------------------------------------
// Usage:
//   A command word is taken when start is high and busy is low. Start, sample
//   and a finish with a zero span answer in the cycle after acceptance.
//   A good finish runs two divisions on the shared divider.
//   A heading runs two sin/cos passes and one atan2 pass on the shared CORDIC
//   and the tilt products on the shared multiplier.
//   busy stays high during a heading or a good finish until the result word is
//   written; the result then sits on the rsp_ ports for one cycle under
//   rsp_strobe, and a new command may be accepted in that same cycle.
//   The receiver cannot stall; every result word is seen exactly once.
//   Reset (synchronous) restores the trackers to +/-3200, offsets to zero,
//   scales to 1.0, two-axis mode and the default declination.
//   csr_ writes take effect at the clock edge; write only while idle.
// ----------------------------------------------------------------------------
`include "mag_calibrate_tilt_heading_top_macros.svh"

module mag_calibrate_tilt_heading_top #(
   parameter int CORDIC_STEPS    = 16,
   parameter int SCALE_FRAC_BITS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic signed [15:0] req_mag_x,
   input  logic signed [15:0] req_mag_y,
   input  logic signed [15:0] req_mag_z,
   input  logic signed [16:0] req_pitch_angle,
   input  logic signed [16:0] req_roll_angle,
   input  logic               csr_write_enable,
   input  logic [0:0]         csr_index,
   input  logic [16:0]        csr_write_data,
   output logic               rsp_strobe,
   output logic [16:0]        rsp_heading,
   output logic signed [17:0] rsp_horizontal_x,
   output logic signed [17:0] rsp_horizontal_y,
   output logic [1:0]         rsp_status
);

   localparam int SCALE_W = SCALE_FRAC_BITS + 4;
   localparam int DEN_W   = 18;
   localparam int NUM_W   = DEN_W + SCALE_FRAC_BITS + 1;
   localparam int CW      = mth_pkg::CORDIC_W;
   localparam int AW      = mth_pkg::ANGLE_W;
   localparam logic [3:0] LAST_STEP = 4'd9;

   mth_pkg::state_type state_ff, state_in;

   logic               three_axis_ff, three_axis_in;
   logic signed [16:0] decl_ff, decl_in;
   logic signed [15:0] min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic signed [15:0] min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic signed [15:0] min_z_ff, min_z_in, max_z_ff, max_z_in;
   logic signed [16:0] off_x_ff, off_x_in, off_y_ff, off_y_in;
   logic [SCALE_W-1:0] scale_x_ff, scale_x_in, scale_y_ff, scale_y_in;

   logic signed [15:0] mx_ff, mx_in, my_ff, my_in, mz_ff, mz_in;
   logic signed [16:0] roll_ff, roll_in;
   logic               flip_p_ff, flip_p_in, flip_r_ff, flip_r_in;
   logic signed [31:0] cp_ff, cp_in, sp_ff, sp_in, cr_ff, cr_in, sr_ff, sr_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in, t1_ff, t1_in, t2_ff, t2_in;
   logic signed [31:0] xh_ff, xh_in, yh_ff, yh_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [3:0]         step_ff, step_in;
   logic [17:0]        sum_ff, sum_in;
   logic [15:0]        sx_ff, sx_in, sy_ff, sy_in;
   logic               n3_ff, n3_in;
   logic [NUM_W-1:0]   qx_ff, qx_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [16:0]        rsp_heading_ff, rsp_heading_in;
   logic signed [17:0] rsp_hx_ff, rsp_hx_in, rsp_hy_ff, rsp_hy_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               accept;
   mth_pkg::op_type    op;

   // angle reduction for sin/cos
   logic signed [16:0] ang_sel;
   logic signed [17:0] a_wrap, a_half, a_red;
   logic               a_flip;

   // shared CORDIC
   mth_pkg::cordic_ctrl_type cordic_ctrl;
   logic signed [CW-1:0] c_x0, c_y0, c_xo, c_yo;
   logic signed [AW-1:0] c_z0, c_zo;
   logic                 cordic_done;
   logic                 xneg;
   logic signed [32:0]   vx, vy;

   // shared divider
   logic               div_start, div_done;
   logic [NUM_W-1:0]   div_numer, div_quot;
   logic [DEN_W-1:0]   den_x, den_y, den_sel;
   logic               q_sat;
   logic [SCALE_W-1:0] q_clip;

   // shared multiplier
   mth_pkg::mul_sel_type mul_sel, cons_sel;
   logic signed [31:0]   mul_a, mul_b;
   logic signed [17:0]   cx_src, cy_src;
   logic signed [31:0]   cz;
   logic signed [31:0]   pr_scale, pr_q30;
   logic signed [63:0]   pr_scale_w, pr_q30_w;

   // finish and start arithmetic
   logic signed [16:0] sx_c, sy_c, sz_c;
   logic signed [18:0] sum_c;
   logic               span_bad;
   logic signed [15:0] sentinel;

   // heading wrap-up
   logic signed [17:0] zr;
   logic signed [18:0] hsum, hwrap;
   logic signed [32:0] hxr, hyr;

   function automatic mth_pkg::mul_sel_type sel_of(input logic [3:0] s);
      mth_pkg::mul_sel_type r;
      case (s)
         4'd0:    r = mth_pkg::MS_CX;
         4'd1:    r = mth_pkg::MS_CY;
         4'd2:    r = mth_pkg::MS_XSR;
         4'd3:    r = mth_pkg::MS_ZSR;
         4'd4:    r = mth_pkg::MS_XCP;
         4'd5:    r = mth_pkg::MS_ZSP;
         4'd6:    r = mth_pkg::MS_YCR;
         4'd7:    r = mth_pkg::MS_T1SP;
         4'd8:    r = mth_pkg::MS_T2CP;
         default: r = mth_pkg::MS_NONE;
      endcase
      return r;
   endfunction

   function automatic logic signed [17:0] clamp18(input logic signed [32:0] v);
      logic signed [17:0] r;
      if (v > 33'sd131071) begin
         r = 18'sd131071;
      end else if (v < -33'sd131072) begin
         r = -18'sd131072;
      end else begin
         r = v[17:0];
      end
      return r;
   endfunction

   assign op     = mth_pkg::op_type'(req_operation);
   assign busy   = (state_ff != mth_pkg::ST_IDLE);
   assign accept = start && !busy;

   // ---------------- angle reduction ----------------
   always_comb begin
      ang_sel = (state_ff == mth_pkg::ST_IDLE) ? req_pitch_angle : roll_ff;
      a_wrap  = (ang_sel < 0) ? 18'(ang_sel + mth_pkg::FULL_TURN) : 18'(ang_sel);
      a_half  = (a_wrap >= mth_pkg::HALF_TURN) ? 18'(a_wrap - mth_pkg::FULL_TURN) : a_wrap;
      a_red   = a_half;
      a_flip  = 1'b0;
      if (a_half > mth_pkg::QUARTER_TURN) begin
         a_red  = 18'(mth_pkg::HALF_TURN - a_half);
         a_flip = 1'b1;
      end else if (a_half < -mth_pkg::QUARTER_TURN) begin
         a_red  = 18'(-mth_pkg::HALF_TURN - a_half);
         a_flip = 1'b1;
      end
   end

   // ---------------- CORDIC operands ----------------
   always_comb begin
      xneg = xh_ff[31];
      vx   = xneg ? -$signed({xh_ff[31], xh_ff}) : $signed({xh_ff[31], xh_ff});
      vy   = xneg ? -$signed({yh_ff[31], yh_ff}) : $signed({yh_ff[31], yh_ff});
      if (state_ff == mth_pkg::ST_VEC_START) begin
         c_x0 = {{(CW - 49){vx[32]}}, vx, 16'b0};
         c_y0 = {{(CW - 49){vy[32]}}, vy, 16'b0};
         c_z0 = xneg ? AW'(mth_pkg::HALF_TURN_FINE) : '0;
      end else begin
         c_x0 = CW'(mth_pkg::CORDIC_K_Q30);
         c_y0 = '0;
         c_z0 = {{(AW - 26){a_red[17]}}, a_red, 8'b0};
      end
   end

   mth_cordic #(
      .STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (cordic_ctrl),
      .x_start (c_x0),
      .y_start (c_y0),
      .z_start (c_z0),
      .done    (cordic_done),
      .x_out   (c_xo),
      .y_out   (c_yo),
      .z_out   (c_zo)
   );

   // ---------------- divider operands ----------------
   always_comb begin
      den_x     = n3_ff ? (18'({sx_ff, 1'b0}) + 18'(sx_ff)) : 18'({sx_ff, 1'b0});
      den_y     = n3_ff ? (18'({sy_ff, 1'b0}) + 18'(sy_ff)) : 18'({sy_ff, 1'b0});
      den_sel   = (state_ff == mth_pkg::ST_DIV_X_START) ? den_x : den_y;
      div_numer = {1'b0, sum_ff, {SCALE_FRAC_BITS{1'b0}}} + NUM_W'(den_sel >> 1);
   end

   mth_div #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (den_sel),
      .done  (div_done),
      .quot  (div_quot)
   );

   // ---------------- shared multiplier ----------------
   always_comb begin
      cx_src   = $signed({mx_ff[15], mx_ff, 1'b0}) - $signed({off_x_ff[16], off_x_ff});
      cy_src   = $signed({my_ff[15], my_ff, 1'b0}) - $signed({off_y_ff[16], off_y_ff});
      cz       = $signed({{12{mz_ff[15]}}, mz_ff, 4'b0});
      mul_sel  = sel_of(step_ff);
      cons_sel = sel_of(step_ff - 4'd1);
      case (mul_sel)
         mth_pkg::MS_CX: begin
            mul_a = 32'(cx_src);
            mul_b = $signed({{(32 - SCALE_W){1'b0}}, scale_x_ff});
         end
         mth_pkg::MS_CY: begin
            mul_a = 32'(cy_src);
            mul_b = $signed({{(32 - SCALE_W){1'b0}}, scale_y_ff});
         end
         mth_pkg::MS_XSR: begin
            mul_a = cx_ff;
            mul_b = sr_ff;
         end
         mth_pkg::MS_ZSR: begin
            mul_a = cz;
            mul_b = sr_ff;
         end
         mth_pkg::MS_XCP: begin
            mul_a = cx_ff;
            mul_b = cp_ff;
         end
         mth_pkg::MS_ZSP: begin
            mul_a = cz;
            mul_b = sp_ff;
         end
         mth_pkg::MS_YCR: begin
            mul_a = cy_ff;
            mul_b = cr_ff;
         end
         mth_pkg::MS_T1SP: begin
            mul_a = t1_ff;
            mul_b = sp_ff;
         end
         mth_pkg::MS_T2CP: begin
            mul_a = t2_ff;
            mul_b = cp_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      pr_scale_w = (prod_ff + (64'sd1 <<< (SCALE_FRAC_BITS - 4))) >>> (SCALE_FRAC_BITS - 3);
      pr_q30_w   = (prod_ff + (64'sd1 <<< 29)) >>> 30;
      pr_scale   = pr_scale_w[31:0];
      pr_q30     = pr_q30_w[31:0];
   end

   // ---------------- finish and heading arithmetic ----------------
   always_comb begin
      sx_c     = 17'(max_x_ff) - 17'(min_x_ff);
      sy_c     = 17'(max_y_ff) - 17'(min_y_ff);
      sz_c     = 17'(max_z_ff) - 17'(min_z_ff);
      sum_c    = 19'(sx_c) + 19'(sy_c) + (three_axis_ff ? 19'(sz_c) : 19'sd0);
      span_bad = (sx_c <= 0) || (sy_c <= 0) || (sum_c <= 0);
      sentinel = three_axis_ff ? 16'sd32000 : 16'sd3200;
      q_sat    = (div_quot[NUM_W-1:SCALE_W] != '0);
      q_clip   = q_sat ? {SCALE_W{1'b1}} : div_quot[SCALE_W-1:0];
      zr       = 18'((c_zo + 26'sd128) >>> 8);
      hsum     = 19'(zr) + 19'(decl_ff);
      if (hsum < 0) begin
         hwrap = hsum + 19'sd92160;
      end else if (hsum >= 19'sd92160) begin
         hwrap = hsum - 19'sd92160;
      end else begin
         hwrap = hsum;
      end
      hxr = ($signed({xh_ff[31], xh_ff}) + 33'sd8) >>> 4;
      hyr = ($signed({yh_ff[31], yh_ff}) + 33'sd8) >>> 4;
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mth_pkg::ST_IDLE: begin
            if (accept && op == mth_pkg::OP_HEADING) begin
               state_in = mth_pkg::ST_ROT_P;
            end else if (accept && op == mth_pkg::OP_FINISH && !span_bad) begin
               state_in = mth_pkg::ST_DIV_X_START;
            end
         end
         mth_pkg::ST_ROT_P: begin
            if (cordic_done) begin
               state_in = mth_pkg::ST_ROT_R;
            end
         end
         mth_pkg::ST_ROT_R: begin
            if (cordic_done) begin
               state_in = mth_pkg::ST_MUL;
            end
         end
         mth_pkg::ST_MUL: begin
            if (step_ff == LAST_STEP) begin
               state_in = mth_pkg::ST_VEC_START;
            end
         end
         mth_pkg::ST_VEC_START: state_in = mth_pkg::ST_VEC;
         mth_pkg::ST_VEC: begin
            if (cordic_done) begin
               state_in = mth_pkg::ST_IDLE;
            end
         end
         mth_pkg::ST_DIV_X_START: state_in = mth_pkg::ST_DIV_X;
         mth_pkg::ST_DIV_X: begin
            if (div_done) begin
               state_in = mth_pkg::ST_DIV_Y;
            end
         end
         mth_pkg::ST_DIV_Y: begin
            if (div_done) begin
               state_in = mth_pkg::ST_IDLE;
            end
         end
         default: state_in = mth_pkg::ST_IDLE;
      endcase
   end

   // ---------------- unit control ----------------
   always_comb begin
      cordic_ctrl.start     = 1'b0;
      cordic_ctrl.vectoring = 1'b0;
      div_start             = 1'b0;
      case (state_ff)
         mth_pkg::ST_IDLE: begin
            cordic_ctrl.start = accept && op == mth_pkg::OP_HEADING;
         end
         mth_pkg::ST_ROT_P: begin
            cordic_ctrl.start = cordic_done;
         end
         mth_pkg::ST_VEC_START: begin
            cordic_ctrl.start     = 1'b1;
            cordic_ctrl.vectoring = 1'b1;
         end
         mth_pkg::ST_DIV_X_START: begin
            div_start = 1'b1;
         end
         mth_pkg::ST_DIV_X: begin
            div_start = div_done;
         end
         default: begin
            cordic_ctrl.start = 1'b0;
         end
      endcase
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      three_axis_in  = three_axis_ff;
      decl_in        = decl_ff;
      min_x_in       = min_x_ff;
      max_x_in       = max_x_ff;
      min_y_in       = min_y_ff;
      max_y_in       = max_y_ff;
      min_z_in       = min_z_ff;
      max_z_in       = max_z_ff;
      off_x_in       = off_x_ff;
      off_y_in       = off_y_ff;
      scale_x_in     = scale_x_ff;
      scale_y_in     = scale_y_ff;
      mx_in          = mx_ff;
      my_in          = my_ff;
      mz_in          = mz_ff;
      roll_in        = roll_ff;
      flip_p_in      = flip_p_ff;
      flip_r_in      = flip_r_ff;
      cp_in          = cp_ff;
      sp_in          = sp_ff;
      cr_in          = cr_ff;
      sr_in          = sr_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      t1_in          = t1_ff;
      t2_in          = t2_ff;
      xh_in          = xh_ff;
      yh_in          = yh_ff;
      prod_in        = mul_a * mul_b;
      step_in        = step_ff;
      sum_in         = sum_ff;
      sx_in          = sx_ff;
      sy_in          = sy_ff;
      n3_in          = n3_ff;
      qx_in          = qx_ff;
      rsp_strobe_in  = 1'b0;
      rsp_heading_in = rsp_heading_ff;
      rsp_hx_in      = rsp_hx_ff;
      rsp_hy_in      = rsp_hy_ff;
      rsp_status_in  = rsp_status_ff;

      if (csr_write_enable) begin
         if (csr_index == 1'b0) begin
            three_axis_in = csr_write_data[0];
         end else begin
            decl_in = $signed(csr_write_data);
         end
      end

      case (state_ff)
         mth_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_heading_in = '0;
               rsp_hx_in      = '0;
               rsp_hy_in      = '0;
               rsp_status_in  = mth_pkg::STATUS_OK;
               mx_in          = req_mag_x;
               my_in          = req_mag_y;
               mz_in          = req_mag_z;
               roll_in        = req_roll_angle;
               flip_p_in      = a_flip;
               case (op)
                  mth_pkg::OP_START: begin
                     rsp_strobe_in = 1'b1;
                     min_x_in = sentinel;
                     min_y_in = sentinel;
                     min_z_in = sentinel;
                     max_x_in = -sentinel;
                     max_y_in = -sentinel;
                     max_z_in = -sentinel;
                  end
                  mth_pkg::OP_SAMPLE: begin
                     rsp_strobe_in = 1'b1;
                     if (req_mag_x < min_x_ff) min_x_in = req_mag_x;
                     if (req_mag_x > max_x_ff) max_x_in = req_mag_x;
                     if (req_mag_y < min_y_ff) min_y_in = req_mag_y;
                     if (req_mag_y > max_y_ff) max_y_in = req_mag_y;
                     if (req_mag_z < min_z_ff) min_z_in = req_mag_z;
                     if (req_mag_z > max_z_ff) max_z_in = req_mag_z;
                  end
                  mth_pkg::OP_FINISH: begin
                     off_x_in = 17'(max_x_ff) + 17'(min_x_ff);
                     off_y_in = 17'(max_y_ff) + 17'(min_y_ff);
                     sum_in   = sum_c[17:0];
                     sx_in    = sx_c[15:0];
                     sy_in    = sy_c[15:0];
                     n3_in    = three_axis_ff;
                     if (span_bad) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = mth_pkg::STATUS_ZERO_SPAN;
                     end
                  end
                  default: begin
                     step_in = '0;
                  end
               endcase
            end
         end
         mth_pkg::ST_ROT_P: begin
            if (cordic_done) begin
               cp_in     = flip_p_ff ? -c_xo[31:0] : c_xo[31:0];
               sp_in     = c_yo[31:0];
               flip_r_in = a_flip;
            end
         end
         mth_pkg::ST_ROT_R: begin
            if (cordic_done) begin
               cr_in   = flip_r_ff ? -c_xo[31:0] : c_xo[31:0];
               sr_in   = c_yo[31:0];
               step_in = '0;
            end
         end
         mth_pkg::ST_MUL: begin
            step_in = step_ff + 4'd1;
            // retire the product issued on the previous step
            if (step_ff != 4'd0) begin
               case (cons_sel)
                  mth_pkg::MS_CX:   cx_in = pr_scale;
                  mth_pkg::MS_CY:   cy_in = pr_scale;
                  mth_pkg::MS_XSR:  t1_in = pr_q30;
                  mth_pkg::MS_ZSR:  t2_in = pr_q30;
                  mth_pkg::MS_XCP:  xh_in = pr_q30;
                  mth_pkg::MS_ZSP:  xh_in = xh_ff + pr_q30;
                  mth_pkg::MS_YCR:  yh_in = pr_q30;
                  mth_pkg::MS_T1SP: yh_in = yh_ff + pr_q30;
                  mth_pkg::MS_T2CP: yh_in = yh_ff + pr_q30;
                  default:          cx_in = cx_ff;
               endcase
            end
         end
         mth_pkg::ST_VEC: begin
            if (cordic_done) begin
               rsp_strobe_in  = 1'b1;
               rsp_heading_in = hwrap[16:0];
               rsp_hx_in      = clamp18(hxr);
               rsp_hy_in      = clamp18(hyr);
               rsp_status_in  = mth_pkg::STATUS_OK;
            end
         end
         mth_pkg::ST_DIV_X: begin
            if (div_done) begin
               qx_in = div_quot;
            end
         end
         mth_pkg::ST_DIV_Y: begin
            if (div_done) begin
               rsp_strobe_in = 1'b1;
               if (qx_ff[NUM_W-1:SCALE_W] != '0) begin
                  scale_x_in = {SCALE_W{1'b1}};
               end else begin
                  scale_x_in = qx_ff[SCALE_W-1:0];
               end
               scale_y_in = q_clip;
               if (q_sat || qx_ff[NUM_W-1:SCALE_W] != '0) begin
                  rsp_status_in = mth_pkg::STATUS_SATURATED;
               end else begin
                  rsp_status_in = mth_pkg::STATUS_OK;
               end
            end
         end
         default: begin
            step_in = step_ff;
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mth_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         three_axis_ff <= 1'b0;
         decl_ff       <= 17'sd1544;
         min_x_ff      <= 16'sd3200;
         min_y_ff      <= 16'sd3200;
         min_z_ff      <= 16'sd3200;
         max_x_ff      <= -16'sd3200;
         max_y_ff      <= -16'sd3200;
         max_z_ff      <= -16'sd3200;
         off_x_ff      <= '0;
         off_y_ff      <= '0;
         scale_x_ff    <= SCALE_W'(1) << SCALE_FRAC_BITS;
         scale_y_ff    <= SCALE_W'(1) << SCALE_FRAC_BITS;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         three_axis_ff <= three_axis_in;
         decl_ff       <= decl_in;
         min_x_ff      <= min_x_in;
         min_y_ff      <= min_y_in;
         min_z_ff      <= min_z_in;
         max_x_ff      <= max_x_in;
         max_y_ff      <= max_y_in;
         max_z_ff      <= max_z_in;
         off_x_ff      <= off_x_in;
         off_y_ff      <= off_y_in;
         scale_x_ff    <= scale_x_in;
         scale_y_ff    <= scale_y_in;
      end
      mx_ff          <= mx_in;
      my_ff          <= my_in;
      mz_ff          <= mz_in;
      roll_ff        <= roll_in;
      flip_p_ff      <= flip_p_in;
      flip_r_ff      <= flip_r_in;
      cp_ff          <= cp_in;
      sp_ff          <= sp_in;
      cr_ff          <= cr_in;
      sr_ff          <= sr_in;
      cx_ff          <= cx_in;
      cy_ff          <= cy_in;
      t1_ff          <= t1_in;
      t2_ff          <= t2_in;
      xh_ff          <= xh_in;
      yh_ff          <= yh_in;
      prod_ff        <= prod_in;
      step_ff        <= step_in;
      sum_ff         <= sum_in;
      sx_ff          <= sx_in;
      sy_ff          <= sy_in;
      n3_ff          <= n3_in;
      qx_ff          <= qx_in;
      rsp_heading_ff <= rsp_heading_in;
      rsp_hx_ff      <= rsp_hx_in;
      rsp_hy_ff      <= rsp_hy_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_heading      = rsp_heading_ff;
   assign rsp_horizontal_x = rsp_hx_ff;
   assign rsp_horizontal_y = rsp_hy_ff;
   assign rsp_status       = rsp_status_ff;

   // ---------------- assertions ----------------
   `MTH_ASSERT_NEXT(a_heading_goes_busy, accept && op == mth_pkg::OP_HEADING, busy && !rsp_strobe)
   `MTH_ASSERT_IMPL(a_cordic_done_state, cordic_done, state_ff == mth_pkg::ST_ROT_P || state_ff == mth_pkg::ST_ROT_R || state_ff == mth_pkg::ST_VEC)
   `MTH_ASSERT_IMPL(a_div_done_state, div_done, state_ff == mth_pkg::ST_DIV_X || state_ff == mth_pkg::ST_DIV_Y)
   `MTH_ASSERT_IMPL(a_flagged_no_heading, rsp_strobe && rsp_status != mth_pkg::STATUS_OK, rsp_heading == 17'd0 && rsp_horizontal_x == 18'sd0)

endmodule

### hdl/mth_cordic.sv
// ----------------------------------------------------------------------------
// mth_cordic
// Shared iterative CORDIC, one micro-rotation per cycle, rotation or vectoring.
// ----------------------------------------------------------------------------
module mth_cordic #(
   parameter int STEPS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  mth_pkg::cordic_ctrl_type                  ctrl,
   input  logic signed [mth_pkg::CORDIC_W-1:0]       x_start,
   input  logic signed [mth_pkg::CORDIC_W-1:0]       y_start,
   input  logic signed [mth_pkg::ANGLE_W-1:0]        z_start,
   output logic                                      done,
   output logic signed [mth_pkg::CORDIC_W-1:0]       x_out,
   output logic signed [mth_pkg::CORDIC_W-1:0]       y_out,
   output logic signed [mth_pkg::ANGLE_W-1:0]        z_out
);

   localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic                                 run_ff, run_in;
   logic                                 done_ff, done_in;
   logic                                 vec_ff, vec_in;
   logic [IW-1:0]                        step_ff, step_in;
   logic signed [mth_pkg::CORDIC_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [mth_pkg::ANGLE_W-1:0]   z_ff, z_in;
   logic signed [mth_pkg::CORDIC_W-1:0]  dx, dy;
   logic signed [mth_pkg::ANGLE_W-1:0]   ang;
   logic                                 ccw;

   always_comb begin
      dx  = y_ff >>> step_ff;
      dy  = x_ff >>> step_ff;
      ang = mth_pkg::angle_entry(5'(step_ff));
      ccw = vec_ff ? !(y_ff > 0) : (z_ff >= 0);
      run_in  = run_ff;
      done_in = 1'b0;
      vec_in  = vec_ff;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (ctrl.start) begin
         run_in  = 1'b1;
         vec_in  = ctrl.vectoring;
         step_in = '0;
         x_in    = x_start;
         y_in    = y_start;
         z_in    = z_start;
      end else if (run_ff) begin
         if (ccw) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + ang;
         end
         if (step_ff == IW'(STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      vec_ff  <= vec_in;
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

### hdl/mth_div.sv
// ----------------------------------------------------------------------------
// mth_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mth_div #(
   parameter int NUM_W = 33,
   parameter int DEN_W = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CW = $clog2(NUM_W);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, q_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         q_in   = numer;
         rem_in = '0;
         den_in = denom;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DEN_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         if (cnt_ff == CW'(NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

### tb/mag_calibrate_tilt_heading_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mag_calibrate_tilt_heading_top_tb
// Self-checking bench for the magnetometer heading engine: calibration
// sequences and tilt-compensated heading words are predicted bit-exactly and
// every result word is compared field by field.
// ----------------------------------------------------------------------------
module mag_calibrate_tilt_heading_top_tb;
   import mth_pkg::*;

   localparam logic [0:0] REG_THREE_AXIS  = 1'd0;
   localparam logic [0:0] REG_DECLINATION = 1'd1;
   localparam int STEPS      = 16;
   localparam int FRAC       = 14;
   localparam int NUM_ITEMS  = 1150;
   localparam int CYCLE_CAP  = 1000000;
   localparam int DRAIN_WAIT = 80;

   typedef struct packed {
      logic [16:0] heading;
      logic [17:0] hx;
      logic [17:0] hy;
      logic [1:0]  status;
   } heading_word_t;

   // ------------------------------------------------------------------------
   class heading_scoreboard;
      longint atan_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
         58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
         57, 29, 14, 7, 4, 2, 1, 0};
      bit three_axis;
      logic signed [16:0] decl;
      longint lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
      longint ofs_x, ofs_y, gain_x, gain_y;
      heading_word_t pending[$];
      int errors, zero_spans, saturations, headings;

      function new();
         three_axis = 0;
         decl = 17'sd1544;
         lo_x = 3200; lo_y = 3200; lo_z = 3200;
         hi_x = -3200; hi_y = -3200; hi_z = -3200;
         ofs_x = 0; ofs_y = 0;
         gain_x = 1 << FRAC; gain_y = 1 << FRAC;
      endfunction

      function longint round_shift(longint v, int s);
         if (s == 0) return v;
         return (v + (longint'(1) << (s - 1))) >>> s;
      endfunction

      function longint wrap360(longint a);
         longint r;
         r = a % FULL_TURN;
         if (r < 0) r += FULL_TURN;
         return r;
      endfunction

      function longint q30_mul(longint a, longint b);
         return round_shift(a * b, 30);
      endfunction

      function void rotate(longint ang, output longint c, output longint s);
         longint a, x, y, z, dx, dy;
         bit flip;
         a = wrap360(ang);
         x = CORDIC_K_Q30; y = 0; flip = 0;
         if (a >= HALF_TURN) a -= FULL_TURN;
         if (a > QUARTER_TURN) begin
            a = HALF_TURN - a; flip = 1;
         end else if (a < -QUARTER_TURN) begin
            a = -HALF_TURN - a; flip = 1;
         end
         z = a * 256;
         for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_tab[i];
            end else begin
               x += dx; y -= dy; z += atan_tab[i];
            end
         end
         c = flip ? -x : x;
         s = y;
      endfunction

      function longint vector_angle(longint x, longint y);
         longint z, dx, dy;
         z = 0;
         if (x < 0) begin
            x = -x; y = -y; z = HALF_TURN_FINE;
         end
         x *= 65536; y *= 65536;
         for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (y > 0) begin
               x += dx; y -= dy; z += atan_tab[i];
            end else begin
               x -= dx; y += dy; z -= atan_tab[i];
            end
         end
         return z;
      endfunction

      function longint soft_iron(longint sum, longint n, longint span, inout bit sat);
         longint lim, den, q;
         lim = (longint'(1) << (FRAC + 4)) - 1;
         den = n * span;
         q = ((sum << FRAC) + den / 2) / den;
         if (q > lim) begin
            sat = 1; return lim;
         end
         return q;
      endfunction

      function longint sat18(longint v);
         if (v > 131071) return 131071;
         if (v < -131072) return -131072;
         return v;
      endfunction

      function void note_command(logic [1:0] op, logic signed [15:0] mx,
            logic signed [15:0] my, logic signed [15:0] mz,
            logic signed [16:0] pitch, logic signed [16:0] roll);
         heading_word_t w;
         longint sx, sy, sz, n, sum, cp, sp, cr, sr, cx, cy, cz, xh, yh, sent;
         bit sat;
         w = '0;
         case (op)
            OP_START: begin
               sent = three_axis ? 32000 : 3200;
               lo_x = sent; lo_y = sent; lo_z = sent;
               hi_x = -sent; hi_y = -sent; hi_z = -sent;
            end
            OP_SAMPLE: begin
               if (mx < lo_x) lo_x = mx;
               if (mx > hi_x) hi_x = mx;
               if (my < lo_y) lo_y = my;
               if (my > hi_y) hi_y = my;
               if (mz < lo_z) lo_z = mz;
               if (mz > hi_z) hi_z = mz;
            end
            OP_FINISH: begin
               sx = hi_x - lo_x; sy = hi_y - lo_y; sz = hi_z - lo_z;
               n = three_axis ? 3 : 2;
               sum = sx + sy + (three_axis ? sz : 0);
               ofs_x = hi_x + lo_x;
               ofs_y = hi_y + lo_y;
               if (sx <= 0 || sy <= 0 || sum <= 0) begin
                  w.status = STATUS_ZERO_SPAN;
                  zero_spans++;
               end else begin
                  sat = 0;
                  gain_x = soft_iron(sum, n, sx, sat);
                  gain_y = soft_iron(sum, n, sy, sat);
                  w.status = sat ? STATUS_SATURATED : STATUS_OK;
                  if (sat) saturations++;
               end
            end
            default: begin
               rotate(longint'(pitch), cp, sp);
               rotate(longint'(roll), cr, sr);
               cx = round_shift((2 * longint'(mx) - ofs_x) * gain_x, FRAC - 3);
               cy = round_shift((2 * longint'(my) - ofs_y) * gain_y, FRAC - 3);
               cz = longint'(mz) * 16;
               xh = q30_mul(cx, cp) + q30_mul(cz, sp);
               yh = q30_mul(q30_mul(cx, sr), sp) + q30_mul(cy, cr)
                  + q30_mul(q30_mul(cz, sr), cp);
               w.hx = sat18(round_shift(xh, 4));
               w.hy = sat18(round_shift(yh, 4));
               w.heading = wrap360(round_shift(vector_angle(xh, yh), 8)
                  + longint'(decl));
               headings++;
            end
         endcase
         pending.push_back(w);
      endfunction

      function void check_word(heading_word_t got);
         heading_word_t e;
         if (pending.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.heading !== e.heading) begin
            $error("heading exp %0d got %0d", e.heading, got.heading); errors++;
         end
         if (got.hx !== e.hx) begin
            $error("horizontal_x exp %0d got %0d", $signed(e.hx), $signed(got.hx));
            errors++;
         end
         if (got.hy !== e.hy) begin
            $error("horizontal_y exp %0d got %0d", $signed(e.hy), $signed(got.hy));
            errors++;
         end
         if (got.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, got.status); errors++;
         end
      endfunction
   endclass
   // ------------------------------------------------------------------------

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_operation = '0;
   logic signed [15:0] req_mag_x = '0, req_mag_y = '0, req_mag_z = '0;
   logic signed [16:0] req_pitch_angle = '0, req_roll_angle = '0;
   logic csr_write_enable = 0;
   logic [0:0] csr_index = '0;
   logic [16:0] csr_write_data = '0;
   logic rsp_strobe;
   logic [16:0] rsp_heading;
   logic signed [17:0] rsp_horizontal_x, rsp_horizontal_y;
   logic [1:0] rsp_status;

   heading_scoreboard sb = new();
   int items_sent = 0;
   int burst_left = 0;
   int cycles = 0;
   int config_changes = 0;

   mag_calibrate_tilt_heading_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_mag_x(req_mag_x), .req_mag_y(req_mag_y),
      .req_mag_z(req_mag_z), .req_pitch_angle(req_pitch_angle),
      .req_roll_angle(req_roll_angle), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data),
      .rsp_strobe(rsp_strobe), .rsp_heading(rsp_heading),
      .rsp_horizontal_x(rsp_horizontal_x), .rsp_horizontal_y(rsp_horizontal_y),
      .rsp_status(rsp_status)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // check older word first, then note the newly accepted one
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_word({rsp_heading, rsp_horizontal_x, rsp_horizontal_y, rsp_status});
         if (start && !busy)
            sb.note_command(req_operation, req_mag_x, req_mag_y, req_mag_z,
               req_pitch_angle, req_roll_angle);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_CAP) begin
         $display("cycle limit reached");
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_word(logic [1:0] op, logic signed [15:0] mx,
         logic signed [15:0] my, logic signed [15:0] mz,
         logic signed [16:0] pitch, logic signed [16:0] roll);
      bit taken;
      @(negedge clock);
      start = 1;
      req_operation = op;
      req_mag_x = mx; req_mag_y = my; req_mag_z = mz;
      req_pitch_angle = pitch; req_roll_angle = roll;
      do begin
         @(posedge clock);
         taken = !busy;
      end while (!taken);
      items_sent++;
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 30);
         if ($urandom_range(0, 3) != 0) begin
            @(negedge clock);
            start = 0;
            repeat ($urandom_range(0, 15)) @(negedge clock);
         end
      end
   endtask

   // wait for every word to come back, then write the register
   task automatic write_reg(logic [0:0] idx, logic [16:0] data);
      @(negedge clock);
      start = 0;
      while (sb.pending.size() != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_enable = 1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 0;
      if (idx == REG_THREE_AXIS) sb.three_axis = data[0];
      else sb.decl = data;
      config_changes++;
   endtask

   function automatic logic signed [16:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return -17'sd46080;
         1: return 17'sd46080;
         default: return $signed(17'($urandom_range(0, 92160))) - 17'sd46080;
      endcase
   endfunction

   function automatic logic signed [15:0] near(int center, int spread);
      int v;
      v = center + $urandom_range(0, 2 * spread) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   task automatic calibration_run();
      int cx, cy, cz, spread, n;
      cx = $urandom_range(0, 4000) - 2000;
      cy = $urandom_range(0, 4000) - 2000;
      cz = $urandom_range(0, 4000) - 2000;
      spread = ($urandom_range(0, 7) == 0) ? 30000 : $urandom_range(1, 3000);
      n = $urandom_range(0, 12);
      send_word(OP_START, 16'($urandom), 16'($urandom), 16'($urandom),
         rand_angle(), rand_angle());
      repeat (n)
         send_word(OP_SAMPLE, near(cx, spread), near(cy, spread),
            near(cz, spread), rand_angle(), rand_angle());
      send_word(OP_FINISH, 16'($urandom), 16'($urandom), 16'($urandom),
         rand_angle(), rand_angle());
      repeat ($urandom_range(1, 8))
         send_word(OP_HEADING, near(cx, spread), near(cy, spread),
            near(cz, spread), rand_angle(), rand_angle());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: defaults, zero vector, extremes, zero span, saturated scale
      send_word(OP_HEADING, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 17'sd0);
      send_word(OP_HEADING, 16'sd1000, 16'sd0, 16'sd0, 17'sd0, 17'sd0);
      send_word(OP_HEADING, 16'sh7fff, 16'sh8000, 16'sh7fff, 17'sd46080, -17'sd46080);
      send_word(OP_HEADING, 16'sh8000, 16'sh7fff, 16'sh8000, -17'sd46080, 17'sd46080);
      send_word(OP_HEADING, -16'sd500, -16'sd700, 16'sd300, 17'sd23040, -17'sd23040);
      send_word(OP_FINISH, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 17'sd0);
      send_word(OP_START, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 17'sd0);
      send_word(OP_FINISH, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 17'sd0);
      send_word(OP_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 17'sd0);
      send_word(OP_SAMPLE, 16'sd1, 16'sd1000, 16'sd5, 17'sd0, 17'sd0);
      send_word(OP_FINISH, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 17'sd0);
      send_word(OP_HEADING, 16'sd1, 16'sd900, 16'sd0, 17'sd100, 17'sd200);
      send_word(OP_START, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 17'sd0);
      send_word(OP_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000, 17'sd0, 17'sd0);
      send_word(OP_SAMPLE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 17'sd0, 17'sd0);
      send_word(OP_FINISH, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 17'sd0);
      send_word(OP_HEADING, 16'sh7fff, 16'sh7fff, 16'sh7fff, 17'sd46080, 17'sd46080);
      send_word(OP_HEADING, 16'sh8000, 16'sh8000, 16'sh8000, -17'sd46080, -17'sd46080);
      write_reg(REG_THREE_AXIS, 17'd1);
      write_reg(REG_DECLINATION, 17'h1_4c00);  // -180 degrees
      send_word(OP_START, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 17'sd0);
      send_word(OP_SAMPLE, -16'sd800, 16'sd100, 16'sd40, 17'sd0, 17'sd0);
      send_word(OP_SAMPLE, 16'sd900, -16'sd300, 16'sd40, 17'sd0, 17'sd0);
      send_word(OP_FINISH, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 17'sd0);
      send_word(OP_HEADING, 16'sd50, 16'sd50, -16'sd20, 17'sd5000, -17'sd7000);
      write_reg(REG_DECLINATION, 17'd46080);

      // random: occasional register writes, mostly well-formed calibration runs, some loose words
      while (items_sent < NUM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: write_reg(REG_THREE_AXIS, 17'($urandom_range(0, 1)));
               1: write_reg(REG_DECLINATION, 17'h1_4c00);
               2: write_reg(REG_DECLINATION, 17'd46080);
               default: write_reg(REG_DECLINATION,
                  17'($urandom_range(0, 92160) - 46080));
            endcase
         end
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 5))
               send_word(2'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), rand_angle(), rand_angle());
         else
            calibration_run();
      end

      @(negedge clock);
      start = 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      $display("%0d command words, %0d headings, %0d zero spans, %0d saturated scales",
         items_sent, sb.headings, sb.zero_spans, sb.saturations);
      $display("%0d register writes across both calibration modes", config_changes);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### mag_calibrate_tilt_heading_top.f
+incdir+hdl
hdl/mth_pkg.sv
hdl/mth_cordic.sv
hdl/mth_div.sv
hdl/mag_calibrate_tilt_heading_top.sv
tb/mag_calibrate_tilt_heading_top_tb.sv
